@@ design/glv_pkg.sv @@
`timescale 1ns / 1ps
// GLV scalar split: curve constants, pipeline latencies and the result word type.
// No dependencies; used by every module of the block.
package glv_pkg;

  localparam int KW = 256;               // scalar width
  localparam int PW = 512;               // full product width

  localparam logic [KW-1:0] N_ORD =
    256'hFFFFFFFFFFFFFFFF_FFFFFFFFFFFFFFFE_BAAEDCE6AF48A03B_BFD25E8CD0364141;
  // 2^256 mod n = 2^128 + FOLD_C
  localparam logic [KW-1:0] FOLD_C =
    256'h0000000000000000_0000000000000000_4551231950B75FC4_402DA1732FC9BEBF;
  localparam logic [KW-1:0] G1 =
    256'h3086D221A7D46BCD_E86C90E49284EB15_3DAA8A1471E8CA7F_E893209A45DBB031;
  localparam logic [KW-1:0] G2 =
    256'hE4437ED6010E8828_6F547FA90ABFE4C4_221208AC9DF506C6_1571B4AE8AC47F71;
  localparam logic [KW-1:0] NEG_B1 =
    256'h0000000000000000_0000000000000000_E4437ED6010E8828_6F547FA90ABFE4C3;
  localparam logic [KW-1:0] NEG_B2 =
    256'hFFFFFFFFFFFFFFFF_FFFFFFFFFFFFFFFE_8A280AC50774346D_D765CDA83DB1562C;
  localparam logic [KW-1:0] LAMBDA =
    256'h5363AD4CC05C30E0_A5261C028812645A_122E22EA20816678_DF02967C1B23BD72;

  localparam int MUL_LAT  = 5;
  localparam int FOLD_LAT = MUL_LAT + 1;
  localparam int NFOLD    = 4;
  localparam int RED_LAT  = NFOLD * FOLD_LAT + 1;

  // stage indexes inside the top-level pipeline
  localparam int ST_KR   = 0;
  localparam int ST_CG   = ST_KR + MUL_LAT + 1;
  localparam int ST_SUMV = ST_CG + MUL_LAT + 1;
  localparam int ST_K2   = ST_SUMV + RED_LAT;
  localparam int ST_LK2  = ST_K2 + MUL_LAT + RED_LAT;
  localparam int ST_DIFF = ST_LK2 + 1;
  localparam int ST_K1   = ST_DIFF + 1;
  localparam int ST_NEG  = ST_K1 + 1;
  localparam int ST_RES  = ST_NEG + 1;
  localparam int PIPE_LAT = ST_RES + 1;

  localparam int K_DLY  = ST_LK2 - ST_KR;       // k waits for lambda*k2
  localparam int K2_DLY = ST_K1 - ST_K2 - 1;    // k2 waits for k1

  typedef struct packed {
    logic        part2_negative;
    logic [63:0] part2_high;
    logic [63:0] part2_low;
    logic        part1_negative;
    logic [63:0] part1_high;
    logic [63:0] part1_low;
  } result_t;

  localparam int RES_W  = $bits(result_t);
  localparam int OUT_DW = ((RES_W + 7) / 8) * 8;

endpackage

@@ design/glv_scalar_split.sv @@
`timescale 1ns / 1ps
// GLV split of a secp256k1 scalar k into k1 + k2*lambda (mod n), each part as
// magnitude and sign. One word is taken every clock cycle while the skid entry is
// empty; an accepted word passes through three 5-stage multiplier trees and two
// 25-stage fold reductions in series before reaching the output register. An
// output register plus one skid entry sit after the pipeline, so the word leaving
// the pipeline on an output stall is kept; the input is held while the skid entry
// is full. Depends on glv_pkg, glv_mul, glv_fold and glv_modred.
module glv_scalar_split (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // k_limb_0 [63:0], k_limb_1 [127:64], k_limb_2 [191:128], k_limb_3 [255:192]
  input  logic [255:0]                in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // part1_low [63:0], part1_high [127:64], part1_negative [128],
  // part2_low [192:129], part2_high [256:193], part2_negative [257], zeros above
  output logic [glv_pkg::OUT_DW-1:0]  out_tdata
);

  localparam int KW = glv_pkg::KW;
  localparam int PW = glv_pkg::PW;
  localparam int L  = glv_pkg::PIPE_LAT;

  logic                en;
  logic [L-1:0]        vld_r;

  logic [KW-1:0]       kr_r;
  logic [PW-1:0]       pg1, pg2, pb1, pb2, plam;
  logic [128:0]        c1_r, c2_r;
  logic [PW-1:0]       v_r;
  logic [KW-1:0]       k2, lk2;
  logic [KW-1:0]       kd_r  [glv_pkg::K_DLY];
  logic [KW-1:0]       k2d_r [glv_pkg::K2_DLY];
  logic [KW:0]         diff_r;
  logic [KW-1:0]       k1_r, k2x_r;
  logic [KW-1:0]       x1_r, x2_r, n1_r, n2_r;
  logic                neg1, neg2;
  glv_pkg::result_t    res_r, out_data_r, skid_data_r;
  logic                out_valid_r, skid_valid_r;
  logic                pipe_vld;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kr_r <= (in_tdata >= glv_pkg::N_ORD) ? in_tdata - glv_pkg::N_ORD : in_tdata;
    end
  end

  glv_mul u_mul_g1 (.clk(clk), .en(en), .a(kr_r), .b(glv_pkg::G1), .p(pg1));
  glv_mul u_mul_g2 (.clk(clk), .en(en), .a(kr_r), .b(glv_pkg::G2), .p(pg2));

  // rounded top products at bit 384, carry kept
  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= 129'(pg1[511:384]) + 129'(pg1[383]);
      c2_r <= 129'(pg2[511:384]) + 129'(pg2[383]);
    end
  end

  glv_mul u_mul_b1 (.clk(clk), .en(en), .a(KW'(c1_r)), .b(glv_pkg::NEG_B1), .p(pb1));
  glv_mul u_mul_b2 (.clk(clk), .en(en), .a(KW'(c2_r)), .b(glv_pkg::NEG_B2), .p(pb2));

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= pb1 + pb2;
    end
  end

  glv_modred u_red_k2 (.clk(clk), .en(en), .v(v_r), .r(k2));

  glv_mul u_mul_lam (.clk(clk), .en(en), .a(k2), .b(glv_pkg::LAMBDA), .p(plam));

  glv_modred u_red_lk2 (.clk(clk), .en(en), .v(plam), .r(lk2));

  always_ff @(posedge clk) begin
    if (en) begin
      kd_r[0] <= kr_r;
      for (int i = 1; i < glv_pkg::K_DLY; i++) begin
        kd_r[i] <= kd_r[i-1];
      end
      k2d_r[0] <= k2;
      for (int i = 1; i < glv_pkg::K2_DLY; i++) begin
        k2d_r[i] <= k2d_r[i-1];
      end
      diff_r <= {1'b0, kd_r[glv_pkg::K_DLY-1]} - {1'b0, lk2};
      // borrow out means the difference wrapped: add n back
      k1_r   <= diff_r[KW] ? diff_r[KW-1:0] + glv_pkg::N_ORD : diff_r[KW-1:0];
      k2x_r  <= k2d_r[glv_pkg::K2_DLY-1];
      x1_r   <= k1_r;
      x2_r   <= k2x_r;
      n1_r   <= (k1_r == '0)  ? '0 : glv_pkg::N_ORD - k1_r;
      n2_r   <= (k2x_r == '0) ? '0 : glv_pkg::N_ORD - k2x_r;
      res_r.part1_negative <= neg1;
      res_r.part1_low      <= neg1 ? n1_r[63:0]   : x1_r[63:0];
      res_r.part1_high     <= neg1 ? n1_r[127:64] : x1_r[127:64];
      res_r.part2_negative <= neg2;
      res_r.part2_low      <= neg2 ? n2_r[63:0]   : x2_r[63:0];
      res_r.part2_high     <= neg2 ? n2_r[127:64] : x2_r[127:64];
    end
  end

  // bit length of a below that of b: a < b and a < (a ^ b)
  assign neg1 = (n1_r < x1_r) && (n1_r < (n1_r ^ x1_r));
  assign neg2 = (n2_r < x2_r) && (n2_r < (n2_r ^ x2_r));

  assign pipe_vld = en && vld_r[L-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= pipe_vld;
      end
    end else if (pipe_vld) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_r;
    end else if (pipe_vld) begin
      skid_data_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = glv_pkg::OUT_DW'(out_data_r);

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid filled without an output stall");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved while held");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !skid_valid_r)
    else $error("output not cleared by reset");

endmodule

@@ design/glv_mul.sv @@
`timescale 1ns / 1ps
// 256 x 256 pipelined multiplier: 32x32 partial products, then a registered adder tree.
// Depends on glv_pkg.
module glv_mul (
  input  logic                     clk,
  input  logic                     en,
  input  logic [glv_pkg::KW-1:0]   a,
  input  logic [glv_pkg::KW-1:0]   b,
  output logic [glv_pkg::PW-1:0]   p
);

  logic [63:0]  pp_r  [8][8];
  logic [287:0] row_r [8];
  logic [319:0] s_r   [4];
  logic [383:0] q_r   [2];
  logic [511:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        for (int j = 0; j < 8; j++) begin
          pp_r[i][j] <= {32'd0, a[32*i +: 32]} * {32'd0, b[32*j +: 32]};
        end
      end
      // even and odd products of a row do not overlap: two concatenations
      for (int i = 0; i < 8; i++) begin
        row_r[i] <= 288'({pp_r[i][6], pp_r[i][4], pp_r[i][2], pp_r[i][0]}) +
                    (288'({pp_r[i][7], pp_r[i][5], pp_r[i][3], pp_r[i][1]}) << 32);
      end
      for (int m = 0; m < 4; m++) begin
        s_r[m] <= 320'(row_r[2*m]) + (320'(row_r[2*m+1]) << 32);
      end
      for (int h = 0; h < 2; h++) begin
        q_r[h] <= 384'(s_r[2*h]) + (384'(s_r[2*h+1]) << 64);
      end
      p_r <= 512'(q_r[0]) + (512'(q_r[1]) << 128);
    end
  end

  assign p = p_r;

endmodule

@@ design/glv_fold.sv @@
`timescale 1ns / 1ps
// One fold step: w = lo + hi * 2^128 + hi * FOLD_C, congruent to lo + hi * 2^256 mod n.
// Depends on glv_pkg and glv_mul.
module glv_fold (
  input  logic                     clk,
  input  logic                     en,
  input  logic [glv_pkg::PW-1:0]   v,
  output logic [glv_pkg::PW-1:0]   w
);

  logic [glv_pkg::PW-1:0] prod;
  logic [glv_pkg::PW-1:0] base_r [glv_pkg::MUL_LAT];
  logic [glv_pkg::PW-1:0] w_r;

  glv_mul u_mul (
    .clk (clk),
    .en  (en),
    .a   (v[glv_pkg::PW-1:glv_pkg::KW]),
    .b   (glv_pkg::FOLD_C),
    .p   (prod)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      base_r[0] <= glv_pkg::PW'(v[glv_pkg::KW-1:0]) +
                   (glv_pkg::PW'(v[glv_pkg::PW-1:glv_pkg::KW]) << 128);
      for (int i = 1; i < glv_pkg::MUL_LAT; i++) begin
        base_r[i] <= base_r[i-1];
      end
      w_r <= base_r[glv_pkg::MUL_LAT-1] + prod;
    end
  end

  assign w = w_r;

endmodule

@@ design/glv_modred.sv @@
`timescale 1ns / 1ps
// Full reduction mod n of a 512-bit word: four folds, then one conditional subtract.
// Depends on glv_pkg and glv_fold.
module glv_modred (
  input  logic                     clk,
  input  logic                     en,
  input  logic [glv_pkg::PW-1:0]   v,
  output logic [glv_pkg::KW-1:0]   r
);

  logic [glv_pkg::PW-1:0] chain [glv_pkg::NFOLD+1];
  logic [glv_pkg::KW-1:0] x;
  logic [glv_pkg::KW-1:0] r_r;

  assign chain[0] = v;

  for (genvar g = 0; g < glv_pkg::NFOLD; g++) begin : g_fold
    glv_fold u_fold (
      .clk (clk),
      .en  (en),
      .v   (chain[g]),
      .w   (chain[g+1])
    );
  end

  // after four folds the word is below 2^256 < 2n
  assign x = chain[glv_pkg::NFOLD][glv_pkg::KW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= (x >= glv_pkg::N_ORD) ? x - glv_pkg::N_ORD : x;
    end
  end

  assign r = r_r;

endmodule

@@ tb/sv/glv_scalar_split_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for glv_scalar_split: a scoreboard computes each split
// directly with wide arithmetic mod n and checks every result word in order.
// Depends on glv_pkg and the glv_scalar_split RTL.
module glv_scalar_split_test;

  localparam int WDOG_LIMIT = 5000;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN      = 2 * glv_pkg::PIPE_LAT;

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [255:0]                in_tdata;
  logic                        out_tvalid;
  logic                        out_tready;
  logic [glv_pkg::OUT_DW-1:0]  out_tdata;

  glv_scalar_split DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  class split_scoreboard;
    glv_pkg::result_t splits_due[$];
    int      errors;
    int      words_in;
    int      words_out;

    function automatic logic [255:0] mod_n(logic [511:0] x);
      logic [511:0] r;
      r = x % {256'd0, glv_pkg::N_ORD};
      return r[255:0];
    endfunction

    function automatic int bit_len(logic [255:0] x);
      int i;
      for (i = 255; i >= 0; i--)
        if (x[i]) return i + 1;
      return 0;
    endfunction

    // round(k*g / 2^384), the carry of the rounding kept
    function automatic logic [255:0] round_top(logic [255:0] k, logic [255:0] g);
      logic [511:0] p;
      p = {256'd0, k} * {256'd0, g};
      return {128'd0, p[511:384]} + {255'd0, p[383]};
    endfunction

    function automatic void signed_mag(logic [255:0] x, output logic [127:0] mag,
                                       output logic neg);
      logic [255:0] nx;
      nx = (x == 0) ? 256'd0 : glv_pkg::N_ORD - x;
      neg = bit_len(nx) < bit_len(x);
      mag = neg ? nx[127:0] : x[127:0];
    endfunction

    function automatic glv_pkg::result_t split_scalar(logic [255:0] k_in);
      logic [255:0] k, c1, c2, k2, lk2, k1;
      logic [127:0] m;
      logic         s;
      glv_pkg::result_t r;
      k = (k_in >= glv_pkg::N_ORD) ? k_in - glv_pkg::N_ORD : k_in;
      c1 = round_top(k, glv_pkg::G1);
      c2 = round_top(k, glv_pkg::G2);
      k2 = mod_n({256'd0, c1} * {256'd0, glv_pkg::NEG_B1} +
                 {256'd0, c2} * {256'd0, glv_pkg::NEG_B2});
      lk2 = mod_n({256'd0, glv_pkg::LAMBDA} * {256'd0, k2});
      k1 = (k >= lk2) ? k - lk2 : k - lk2 + glv_pkg::N_ORD;
      signed_mag(k1, m, s);
      r.part1_low = m[63:0]; r.part1_high = m[127:64]; r.part1_negative = s;
      signed_mag(k2, m, s);
      r.part2_low = m[63:0]; r.part2_high = m[127:64]; r.part2_negative = s;
      return r;
    endfunction

    function void note_scalar(logic [255:0] k);
      splits_due.push_back(split_scalar(k));
      words_in++;
    endfunction

    task report(string what, logic [127:0] got, logic [127:0] want);
      $display("mismatch on result %0d: %s got %h want %h", words_out, what, got, want);
      errors++;
    endtask

    task check_split(logic [glv_pkg::OUT_DW-1:0] data);
      glv_pkg::result_t got, want;
      got = data[glv_pkg::RES_W-1:0];
      if (splits_due.size() == 0) begin
        report("unexpected word", data[127:0], 128'd0);
      end else begin
        want = splits_due.pop_front();
        if (got.part1_low != want.part1_low)
          report("part1_low", got.part1_low, want.part1_low);
        if (got.part1_high != want.part1_high)
          report("part1_high", got.part1_high, want.part1_high);
        if (got.part1_negative != want.part1_negative)
          report("part1_negative", got.part1_negative, want.part1_negative);
        if (got.part2_low != want.part2_low)
          report("part2_low", got.part2_low, want.part2_low);
        if (got.part2_high != want.part2_high)
          report("part2_high", got.part2_high, want.part2_high);
        if (got.part2_negative != want.part2_negative)
          report("part2_negative", got.part2_negative, want.part2_negative);
      end
      words_out++;
    endtask
  endclass

  split_scoreboard sb;
  int  send_idle;
  int  recv_idle;
  int  phase;
  int  quiet_cycles;
  bit  held;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task send_scalar(logic [255:0] k);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= k;
    do @(posedge clk); while (!in_tready);
    sb.note_scalar(k);
  endtask

  function automatic logic [255:0] rand_scalar();
    logic [255:0] k;
    int sel;
    k = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    sel = $urandom_range(99);
    if (sel < 5)
      // not below n, still below 2^256
      k = glv_pkg::N_ORD + (k % (~glv_pkg::N_ORD + 256'd1));
    else if (sel < 10)
      k = k >> $urandom_range(255);           // short scalars
    else if (sel < 15)
      k = glv_pkg::N_ORD - (k >> $urandom_range(255, 120));
    return k;
  endfunction

  task random_phase(int count);
    repeat (count) send_scalar(rand_scalar());
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  // receiver
  initial begin
    out_tready = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (phase == 3 && !held) begin
        repeat (HOLD_LEN) begin
          out_tready <= 0;
          @(negedge clk);
        end
        held = 1;
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // output check and watchdog
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_split(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", WDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    logic [255:0] directed[$];
    sb = new();
    phase = 0;
    send_idle = 25;
    recv_idle = 67;
    in_tvalid = 0;
    in_tdata = 0;
    rst_n = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    phase = 1;
    directed = '{256'd0, 256'd1, 256'd2, glv_pkg::N_ORD - 1, glv_pkg::N_ORD - 2,
                 glv_pkg::N_ORD, glv_pkg::N_ORD + 1,
                 {256{1'b1}}, glv_pkg::LAMBDA, glv_pkg::LAMBDA + 1,
                 glv_pkg::N_ORD - glv_pkg::LAMBDA,
                 {64'd0, 64'd0, 64'd0, {64{1'b1}}}, {64'd0, 64'd0, {64{1'b1}}, 64'd0},
                 {64'd0, {64{1'b1}}, 64'd0, 64'd0}, {64'h7FFFFFFFFFFFFFFF, 192'd0},
                 {128'd0, {128{1'b1}}}, {1'b1, 255'd0}, glv_pkg::N_ORD >> 1,
                 (glv_pkg::N_ORD >> 1) + 1,
                 {64{4'hA}}, {64{4'h5}}, glv_pkg::G1, glv_pkg::G2};
    foreach (directed[i]) send_scalar(directed[i]);
    random_phase(475);

    phase = 2;
    send_idle = 67;
    recv_idle = 25;
    random_phase(475);

    phase = 3;
    send_idle = 0;
    recv_idle = 0;
    random_phase(475);

    while (sb.splits_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("%0d scalars split and %0d results checked, incl. unreduced inputs,",
             sb.words_in, sb.words_out);
    $display("edge values, both idle mixes and a long output hold-off");
    if (sb.errors == 0 && sb.splits_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ sim.f @@
design/glv_pkg.sv
design/glv_mul.sv
design/glv_fold.sv
design/glv_modred.sv
design/glv_scalar_split.sv
tb/sv/glv_scalar_split_test.sv
